// ===== design/direct_mapped_string_hash_table_unit_defines.svh =====
// assertion macros for the direct-mapped string hash table unit
// no dependencies; included by the top level
`ifndef DIRECT_MAPPED_STRING_HASH_TABLE_UNIT_DEFINES_SVH
`define DIRECT_MAPPED_STRING_HASH_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DMSH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define DMSH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dmsh_pkg.sv =====
// shared constants, types and tables for the direct-mapped string hash table
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package dmsh_pkg;

   localparam int TABLE_SLOTS   = 10;
   localparam int MAX_KEY_CHARS = 8;

   localparam int KIND_W       = 2;
   localparam int KEY_W        = 64;
   localparam int KEY_LEN_W    = 4;
   localparam int SLOT_INDEX_W = 4;
   localparam int CHAR_W       = 8;
   localparam int KEY_BYTES    = KEY_W / CHAR_W;
   localparam int CHAR_VALUES  = 2 ** CHAR_W;

   localparam int IDX_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int BIT_CNT_W = $clog2(IDX_W + 1);

   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [KEY_W-1:0]     key_type;
   typedef logic [KEY_LEN_W-1:0] key_len_type;
   typedef logic [CHAR_W-1:0]    char_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_SEARCH = 2'd1,
      KIND_REMOVE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_LOOKUP
   } state_type;

   // hash unit status toward the controller
   typedef struct packed {
      logic    done;
      idx_type idx;
   } hash_st_type;

   // slot store command from the controller
   typedef struct packed {
      logic    rd_en;
      logic    wr_en;
      logic    clr_en;
      idx_type idx;
   } store_cmd_type;

   // registered slot read data
   typedef struct packed {
      logic        valid;
      key_type     key;
      key_len_type len;
   } store_rd_type;

   typedef logic [CHAR_VALUES-1:0][IDX_W-1:0] char_mod_table_type;

   // character value reduced modulo the slot count
   function automatic char_mod_table_type build_char_mod();
      char_mod_table_type t;
      for (int i = 0; i < CHAR_VALUES; i++) begin
         t[i] = IDX_W'(i % TABLE_SLOTS);
      end
      return t;
   endfunction

   localparam char_mod_table_type CHAR_MOD_TABLE = build_char_mod();

   // byte mask keeping the first len characters
   function automatic key_type key_mask(input key_len_type len);
      key_type m;
      m = '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (KEY_LEN_W'(i) < len) begin
            m[i*CHAR_W +: CHAR_W] = '1;
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== design/dmsh_hash.sv =====
// bit-serial slot hash: one character per pass, one multiplier bit per cycle
// depends on dmsh_pkg
`timescale 1ns / 1ps
`default_nettype none

module dmsh_hash import dmsh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  key_type     key,
   input  key_len_type key_len,
   output hash_st_type status
);

   localparam logic [IDX_W:0] SLOTS_EXT = (IDX_W + 1)'(TABLE_SLOTS);

   key_type               chars_ff, chars_in;
   key_len_type           left_ff, left_in;
   idx_type               h_ff, h_in;
   idx_type               a_ff, a_in;
   idx_type               b_ff, b_in;
   idx_type               acc_ff, acc_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic                  run_ff, run_in;
   logic                  mul_ff, mul_in;
   logic                  done_ff, done_in;

   char_type       c;
   idx_type        a_load;
   idx_type        b_load;
   logic [IDX_W:0] bsum;
   logic [IDX_W:0] dbl;
   logic [IDX_W:0] dbl_red;
   logic [IDX_W:0] addend;
   logic [IDX_W:0] sum;
   idx_type        acc_next;

   // load: a = c mod n, b = (h + c) mod n
   assign c      = chars_ff[CHAR_W-1:0];
   assign a_load = CHAR_MOD_TABLE[c];
   assign bsum   = {1'b0, h_ff} + {1'b0, a_load};
   assign b_load = (bsum >= SLOTS_EXT) ? IDX_W'(bsum - SLOTS_EXT) : IDX_W'(bsum);

   // modular shift-add step, multiplier bits msb first
   assign dbl      = {acc_ff, 1'b0};
   assign dbl_red  = (dbl >= SLOTS_EXT) ? (dbl - SLOTS_EXT) : dbl;
   assign addend   = a_ff[IDX_W-1] ? {1'b0, b_ff} : '0;
   assign sum      = dbl_red + addend;
   assign acc_next = (sum >= SLOTS_EXT) ? IDX_W'(sum - SLOTS_EXT) : IDX_W'(sum);

   always_comb begin
      chars_in   = chars_ff;
      left_in    = left_ff;
      h_in       = h_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      acc_in     = acc_ff;
      bit_cnt_in = bit_cnt_ff;
      run_in     = run_ff;
      mul_in     = mul_ff;
      done_in    = 1'b0;
      priority if (start) begin
         chars_in = key;
         left_in  = key_len;
         h_in     = '0;
         mul_in   = 1'b0;
         if (key_len == '0) begin
            done_in = 1'b1;
            run_in  = 1'b0;
         end else begin
            run_in = 1'b1;
         end
      end else if (run_ff && !mul_ff) begin
         chars_in   = chars_ff >> CHAR_W;
         left_in    = left_ff - 1'b1;
         a_in       = a_load;
         b_in       = b_load;
         acc_in     = '0;
         bit_cnt_in = BIT_CNT_W'(IDX_W - 1);
         mul_in     = 1'b1;
      end else if (run_ff && mul_ff) begin
         acc_in     = acc_next;
         a_in       = a_ff << 1;
         bit_cnt_in = bit_cnt_ff - 1'b1;
         if (bit_cnt_ff == '0) begin
            h_in   = acc_next;
            mul_in = 1'b0;
            if (left_ff == '0) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end
         end
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         mul_ff  <= mul_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff   <= chars_in;
      left_ff    <= left_in;
      h_ff       <= h_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      acc_ff     <= acc_in;
      bit_cnt_ff <= bit_cnt_in;
   end

   assign status.done = done_ff;
   assign status.idx  = h_ff;

endmodule

`default_nettype wire

// ===== design/dmsh_store.sv =====
// slot store: key and length arrays with registered read, per-slot valid bits
// depends on dmsh_pkg
`timescale 1ns / 1ps
`default_nettype none

module dmsh_store import dmsh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  store_cmd_type cmd,
   input  key_type       wr_key,
   input  key_len_type   wr_len,
   output store_rd_type  rd
);

   key_type                slot_key_ff [TABLE_SLOTS];
   key_len_type            slot_len_ff [TABLE_SLOTS];
   logic [TABLE_SLOTS-1:0] valid_ff, valid_in;
   logic                   rd_valid_ff;
   key_type                rd_key_ff;
   key_len_type            rd_len_ff;

   always_comb begin
      valid_in = valid_ff;
      priority if (cmd.wr_en) begin
         valid_in[cmd.idx] = 1'b1;
      end else if (cmd.clr_en) begin
         valid_in[cmd.idx] = 1'b0;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[cmd.idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slot_key_ff[cmd.idx] <= wr_key;
         slot_len_ff[cmd.idx] <= wr_len;
      end
      if (cmd.rd_en) begin
         rd_key_ff <= slot_key_ff[cmd.idx];
         rd_len_ff <= slot_len_ff[cmd.idx];
      end
   end

   assign rd.valid = rd_valid_ff;
   assign rd.key   = rd_key_ff;
   assign rd.len   = rd_len_ff;

endmodule

`default_nettype wire

// ===== design/direct_mapped_string_hash_table_unit.sv =====
// sequence: from accept, each character is hashed in a load step and then one step per
//   multiplier bit, then the slot read and the result beat; a reject answers in the next cycle
// throughput: one item at a time; the next start is taken on the result beat's cycle,
//   the bit-serial hash unit sets the pace (one multiplier bit of c mod n per cycle)
// reset clears all slot valid bits at once; results cannot be stalled by the receiver
// top level: controller, hash unit, slot store; depends on dmsh_pkg and the defines header
`timescale 1ns / 1ps
`default_nettype none

`include "direct_mapped_string_hash_table_unit_defines.svh"

module direct_mapped_string_hash_table_unit import dmsh_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // command side
   input  logic                    start,
   output logic                    busy,
   input  logic [KIND_W-1:0]       req_kind,
   input  logic [KEY_W-1:0]        req_key_chars,
   input  logic [KEY_LEN_W-1:0]    req_key_len,
   // result side, one beat per item
   output logic                    rsp_strobe,
   output logic                    rsp_success,
   output logic [SLOT_INDEX_W-1:0] rsp_slot_index,
   output logic [KEY_W-1:0]        rsp_slot_key,
   output logic [KEY_LEN_W-1:0]    rsp_slot_key_len
);

   // controller state
   state_type   state_ff, state_in;
   kind_type    kind_ff, kind_in;
   key_type     key_ff, key_in;
   key_len_type len_ff, len_in;
   idx_type     idx_ff, idx_in;

   // result beat registers
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_success_ff, rsp_success_in;
   logic [SLOT_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   key_type                 rsp_key_ff, rsp_key_in;
   key_len_type             rsp_len_ff, rsp_len_in;

   logic          accept;
   logic          legal;
   logic          hash_start;
   logic          occupied;
   logic          match;
   hash_st_type   hash_st;
   store_cmd_type store_cmd;
   store_rd_type  store_rd;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // reserved kind code and overlong keys are rejected with an all-zero result
   assign legal = (req_kind == KIND_INSERT || req_kind == KIND_SEARCH ||
                   req_kind == KIND_REMOVE) &&
                  (req_key_len <= KEY_LEN_W'(MAX_KEY_CHARS));

   assign hash_start = accept && legal;

   // slot data is registered, so compare against it in the lookup state
   assign occupied = store_rd.valid;
   assign match    = occupied && (store_rd.len == len_ff) && (store_rd.key == key_ff);

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      key_in         = key_ff;
      len_in         = len_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = 1'b0;
      rsp_success_in = rsp_success_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_len_in     = rsp_len_ff;
      store_cmd      = '{rd_en: 1'b0, wr_en: 1'b0, clr_en: 1'b0, idx: idx_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (legal) begin
                  // bytes past the key length are dropped before hashing and storing
                  state_in = ST_HASH;
                  kind_in  = kind_type'(req_kind);
                  key_in   = req_key_chars & key_mask(req_key_len);
                  len_in   = req_key_len;
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_success_in = 1'b0;
                  rsp_index_in   = '0;
                  rsp_key_in     = '0;
                  rsp_len_in     = '0;
               end
            end
         end
         ST_HASH: begin
            if (hash_st.done) begin
               store_cmd.rd_en = 1'b1;
               store_cmd.idx   = hash_st.idx;
               idx_in          = hash_st.idx;
               state_in        = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_index_in = SLOT_INDEX_W'(idx_ff);
            // occupant reported by default, zeros for an empty slot
            rsp_key_in   = occupied ? store_rd.key : '0;
            rsp_len_in   = occupied ? store_rd.len : '0;
            unique case (kind_ff)
               KIND_INSERT: begin
                  rsp_success_in = !occupied;
                  if (!occupied) begin
                     store_cmd.wr_en = 1'b1;
                     rsp_key_in      = key_ff;
                     rsp_len_in      = len_ff;
                  end
               end
               KIND_SEARCH: begin
                  rsp_success_in = match;
               end
               KIND_REMOVE: begin
                  rsp_success_in   = match;
                  store_cmd.clr_en = match;
               end
               default: begin
                  rsp_success_in = 1'b0;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      key_ff         <= key_in;
      len_ff         <= len_in;
      idx_ff         <= idx_in;
      rsp_success_ff <= rsp_success_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_len_ff     <= rsp_len_in;
   end

   // serial hash over the key characters
   dmsh_hash u_hash (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .key     (req_key_chars & key_mask(req_key_len)),
      .key_len (req_key_len),
      .status  (hash_st)
   );

   // slot storage with valid bits
   dmsh_store u_store (
      .clock  (clock),
      .reset  (reset),
      .cmd    (store_cmd),
      .wr_key (key_ff),
      .wr_len (len_ff),
      .rd     (store_rd)
   );

   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_success      = rsp_success_ff;
   assign rsp_slot_index   = rsp_index_ff;
   assign rsp_slot_key     = rsp_key_ff;
   assign rsp_slot_key_len = rsp_len_ff;

   // legal item keeps the unit busy until its beat
   `DMSH_ASSERT_NEXT(a_legal_goes_busy, clock, reset, hash_start, busy, "legal item not held busy")
   // hash completion only while the controller waits for it
   `DMSH_ASSERT_NOW(a_done_in_hash, clock, reset, hash_st.done, state_ff == ST_HASH, "stray hash done")
   // rejected item answers on the next beat without success
   `DMSH_ASSERT_NEXT(a_reject_beat, clock, reset, accept && !legal, rsp_strobe && !rsp_success, "reject beat missing")
   // reported slot always inside the table
   `DMSH_ASSERT_NOW(a_index_range, clock, reset, rsp_strobe, rsp_slot_index < TABLE_SLOTS, "slot index out of range")

endmodule

`default_nettype wire
